// ===== design/rjsl_pkg.sv =====
// Package for the ramped joint slew limiter.
// Holds the item structs, op codes, register indexes and fixed-point constants.
// No dependencies; every design file refers to it by scoped names.
package rjsl_pkg;

    // Op codes of an input item.
    localparam logic [1:0] OP_FRESH  = 2'd0;
    localparam logic [1:0] OP_STALE  = 2'd1;
    localparam logic [1:0] OP_ENGAGE = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_MAX_STEP   = 1'b0;
    localparam logic CFG_RAMP_STEPS = 1'b1;

    // Configuration port data width (widest register).
    localparam int CFG_W = 16;

    // Ramp fraction is Q1.16 unsigned; one bit is resolved per cycle.
    localparam int               FRAC_W    = 17;
    localparam logic [16:0]      RAMP_ONE  = 17'h10000;
    localparam int               STEP_CW   = 5;
    localparam logic [4:0]       LAST_STEP = 5'(FRAC_W - 1);

    // Register reset values.
    localparam logic [14:0] MAX_STEP_RST   = 15'd41;
    localparam logic [15:0] RAMP_STEPS_RST = 16'd50;

    // Input item.
    typedef struct packed {
        logic [1:0]         op;
        logic [3:0]         joint;
        logic               first_of_step;
        logic signed [15:0] target_position;
        logic signed [15:0] target_torque;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic [3:0]         out_joint;
        logic signed [15:0] out_position;
        logic signed [15:0] out_torque;
    } t_out_item;

endpackage

// ===== design/rjsl_div.sv =====
// Bit-serial restoring divider for the ramp fraction: quotient = num * 65536 / den.
// Resolves one quotient bit per cycle, with num no greater than den.
// Depends on rjsl_pkg.
module rjsl_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_num,
    input  logic [15:0] i_den,
    output logic        o_done,
    output logic [16:0] o_quot
);

    logic                        r_busy, n_busy;
    logic                        r_done, n_done;
    logic [rjsl_pkg::STEP_CW-1:0] r_cnt, n_cnt;
    logic [16:0]                 r_rem, n_rem;
    logic [15:0]                 r_den, n_den;
    logic [16:0]                 r_quot, n_quot;
    logic                        w_ge;
    logic [16:0]                 w_diff;
    logic [16:0]                 w_keep;

    // One compare and subtract per quotient bit.
    always_comb begin
        w_ge   = r_rem >= {1'b0, r_den};
        w_diff = r_rem - {1'b0, r_den};
        w_keep = w_ge ? w_diff : r_rem;
    end

    // Step control.
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quot = r_quot;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = {1'b0, i_num};
            n_den  = i_den;
            n_quot = '0;
        end else if (r_busy) begin
            n_quot = {r_quot[15:0], w_ge};
            n_rem  = {w_keep[15:0], 1'b0};
            n_cnt  = r_cnt + 1'b1;
            if (r_cnt == rjsl_pkg::LAST_STEP) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_quot <= n_quot;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== design/rjsl_mul.sv =====
// Bit-serial shift-add multiplier scaling the slew cap and the torque by the ramp fraction.
// Both products share one multiplier bit per cycle, low bit first.
// Depends on rjsl_pkg.
module rjsl_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [16:0]        i_frac,
    input  logic [14:0]        i_max_step,
    input  logic signed [15:0] i_torque,
    output logic               o_done,
    output logic [15:0]        o_cap,
    output logic signed [15:0] o_torque
);

    logic                         r_busy, n_busy;
    logic                         r_done, n_done;
    logic [rjsl_pkg::STEP_CW-1:0] r_cnt, n_cnt;
    logic [16:0]                  r_mq, n_mq;
    logic [14:0]                  r_mstep, n_mstep;
    logic signed [15:0]           r_tau, n_tau;
    logic [15:0]                  r_cap_hi, n_cap_hi;
    logic [16:0]                  r_cap_lo, n_cap_lo;
    logic signed [16:0]           r_tq_hi, n_tq_hi;
    logic [16:0]                  r_tq_lo, n_tq_lo;
    logic [16:0]                  w_cap_sum;
    logic signed [17:0]           w_tq_sum;
    logic signed [33:0]           w_tq_round;

    // Partial sums for the current multiplier bit.
    always_comb begin
        w_cap_sum = {1'b0, r_cap_hi} + (r_mq[0] ? {2'b00, r_mstep} : 17'd0);
        w_tq_sum  = 18'(r_tq_hi) + (r_mq[0] ? 18'(r_tau) : 18'sd0);
    end

    // Step control: add, then shift the product one place right.
    always_comb begin
        n_busy   = r_busy;
        n_done   = 1'b0;
        n_cnt    = r_cnt;
        n_mq     = r_mq;
        n_mstep  = r_mstep;
        n_tau    = r_tau;
        n_cap_hi = r_cap_hi;
        n_cap_lo = r_cap_lo;
        n_tq_hi  = r_tq_hi;
        n_tq_lo  = r_tq_lo;
        if (i_start) begin
            n_busy   = 1'b1;
            n_cnt    = '0;
            n_mq     = i_frac;
            n_mstep  = i_max_step;
            n_tau    = i_torque;
            n_cap_hi = '0;
            n_cap_lo = '0;
            n_tq_hi  = '0;
            n_tq_lo  = '0;
        end else if (r_busy) begin
            n_mq     = {1'b0, r_mq[16:1]};
            n_cap_hi = w_cap_sum[16:1];
            n_cap_lo = {w_cap_sum[0], r_cap_lo[16:1]};
            n_tq_hi  = w_tq_sum[17:1];
            n_tq_lo  = {w_tq_sum[0], r_tq_lo[16:1]};
            n_cnt    = r_cnt + 1'b1;
            if (r_cnt == rjsl_pkg::LAST_STEP) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_mq     <= n_mq;
        r_mstep  <= n_mstep;
        r_tau    <= n_tau;
        r_cap_hi <= n_cap_hi;
        r_cap_lo <= n_cap_lo;
        r_tq_hi  <= n_tq_hi;
        r_tq_lo  <= n_tq_lo;
    end

    // Cap is the product with its 16 fraction bits dropped.
    assign o_cap = {r_cap_hi[14:0], r_cap_lo[16]};

    // Torque rounds to nearest, ties upward.
    assign w_tq_round = $signed({r_tq_hi, r_tq_lo}) + 34'sd32768;
    assign o_torque   = w_tq_round[31:16];
    assign o_done     = r_done;

endmodule

// ===== design/ramped_joint_slew_limiter.sv =====
// Top level of the ramped joint slew limiter: sequencer, held poses and output register.
// Instantiates rjsl_div and rjsl_mul; depends on rjsl_pkg.
//
//   Channel  | Valid        | Stall        | Payload
//   ---------+--------------+--------------+--------------------------
//   input    | i_in_valid   | o_in_stall   | i_in_item  (t_in_item)
//   output   | o_out_valid  | i_out_stall  | o_out_item (t_out_item)
//   config   | i_cfg_we     | none         | i_cfg_idx, i_cfg_data
//
// A stale or engage item goes from idle straight to output. A fresh item passes through
// load, the 17-step serial multiplier and output; one that starts a control step with a
// nonzero ramp length runs the 17-step divider first. One item is worked at a time.
// Reset is synchronous, active low, and restores registers and held poses.
// A finished item waits in the output register; the next item is accepted meanwhile
// and only its final cycle waits for that register to drain.
module ramped_joint_slew_limiter #(
    parameter int NUM_JOINTS = 14
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  rjsl_pkg::t_in_item            i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output rjsl_pkg::t_out_item           o_out_item,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [rjsl_pkg::CFG_W-1:0]    i_cfg_data
);

    localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
    localparam int IW = ((JW > 4) ? JW : 4) + 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_LOAD = 5'b00100,
        S_MUL  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    rjsl_pkg::t_in_item   r_item;
    logic [14:0]          r_max_step;
    logic [15:0]          r_ramp_steps;
    logic                 r_stale, n_stale;
    logic [15:0]          r_count, n_count;
    logic [16:0]          r_frac, n_frac;
    logic signed [15:0]   r_held [NUM_JOINTS];
    logic                 r_out_valid;
    rjsl_pkg::t_out_item  r_out;

    logic                 w_in_acc;
    logic                 w_out_free;
    logic                 w_out_load;
    logic                 w_div_start;
    logic [15:0]          w_div_num;
    logic                 w_div_done;
    logic [16:0]          w_div_quot;
    logic                 w_mul_done;
    logic [15:0]          w_cap;
    logic signed [15:0]   w_mul_tq;
    logic [IW-1:0]        w_jext;
    logic [JW-1:0]        w_idx;
    logic                 w_valid;
    logic signed [15:0]   w_held;
    logic signed [16:0]   w_delta;
    logic signed [16:0]   w_cap_s;
    logic signed [16:0]   w_clamp;
    logic signed [15:0]   w_new_held;
    rjsl_pkg::t_out_item  w_res;

    // Handshakes.
    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_out_load = (r_state == S_OUT) && w_out_free;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_step   <= rjsl_pkg::MAX_STEP_RST;
            r_ramp_steps <= rjsl_pkg::RAMP_STEPS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rjsl_pkg::CFG_MAX_STEP:   r_max_step   <= i_cfg_data[14:0];
                rjsl_pkg::CFG_RAMP_STEPS: r_ramp_steps <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Step-wide state updates taken on accept, and the sequencer.
    always_comb begin
        n_state     = r_state;
        n_stale     = r_stale;
        n_count     = r_count;
        n_frac      = r_frac;
        w_div_start = 1'b0;
        w_div_num   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    priority if (i_in_item.op == rjsl_pkg::OP_ENGAGE) begin
                        n_stale = 1'b1;
                        n_count = '0;
                        n_frac  = '0;
                        n_state = S_OUT;
                    end else if (i_in_item.op == rjsl_pkg::OP_FRESH) begin
                        n_state = S_LOAD;
                        if (i_in_item.first_of_step) begin
                            n_stale = 1'b0;
                            n_count = r_stale ? 16'd1 :
                                      ((r_count != 16'hFFFF) ? r_count + 16'd1 : r_count);
                            if (r_ramp_steps == 16'd0) begin
                                n_frac = rjsl_pkg::RAMP_ONE;
                            end else begin
                                w_div_start = 1'b1;
                                w_div_num   = (n_count < r_ramp_steps) ? n_count
                                                                       : r_ramp_steps;
                                n_state     = S_DIV;
                            end
                        end
                    end else begin
                        n_stale = 1'b1;
                        n_frac  = '0;
                        n_state = S_OUT;
                    end
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_frac  = w_div_quot;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: n_state = S_MUL;
            S_MUL: begin
                if (w_mul_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stale <= 1'b1;
            r_count <= '0;
            r_frac  <= '0;
        end else begin
            r_state <= n_state;
            r_stale <= n_stale;
            r_count <= n_count;
            r_frac  <= n_frac;
        end
    end

    // Item capture.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_item <= i_in_item;
        end
    end

    // Serial ramp divider.
    rjsl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (r_ramp_steps),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // Serial scaling of cap and torque by the ramp fraction.
    rjsl_mul u_mul (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_LOAD),
        .i_frac     (r_frac),
        .i_max_step (r_max_step),
        .i_torque   (r_item.target_torque),
        .o_done     (w_mul_done),
        .o_cap      (w_cap),
        .o_torque   (w_mul_tq)
    );

    // Joint lookup; out-of-range joints read as zero.
    always_comb begin
        w_jext  = IW'(r_item.joint);
        w_idx   = w_jext[JW-1:0];
        w_valid = w_jext < IW'(NUM_JOINTS);
        w_held  = w_valid ? r_held[w_idx] : 16'sd0;
    end

    // Slew clamp of the step toward the target.
    always_comb begin
        w_delta = 17'(r_item.target_position) - 17'(w_held);
        w_cap_s = $signed({1'b0, w_cap});
        priority if (w_delta > w_cap_s) begin
            w_clamp = w_cap_s;
        end else if (w_delta < -w_cap_s) begin
            w_clamp = -w_cap_s;
        end else begin
            w_clamp = w_delta;
        end
        w_new_held = w_held + w_clamp[15:0];
    end

    // Result formation.
    always_comb begin
        w_res.out_joint    = r_item.joint;
        w_res.out_position = '0;
        w_res.out_torque   = '0;
        if (w_valid) begin
            priority if (r_item.op == rjsl_pkg::OP_ENGAGE) begin
                w_res.out_position = r_item.target_position;
            end else if (r_item.op == rjsl_pkg::OP_FRESH) begin
                w_res.out_position = w_new_held;
                w_res.out_torque   = w_mul_tq;
            end else begin
                w_res.out_position = w_held;
            end
        end
    end

    // Held pose store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NUM_JOINTS; j++) begin
                r_held[j] <= '0;
            end
        end else if (w_out_load && w_valid) begin
            if (r_item.op == rjsl_pkg::OP_ENGAGE) begin
                r_held[w_idx] <= r_item.target_position;
            end else if (r_item.op == rjsl_pkg::OP_FRESH) begin
                r_held[w_idx] <= w_new_held;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_out_load) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
